### rtl/psd_pkg.sv
package psd_pkg;

  localparam int unsigned MaxTerms = 1024;
  localparam int unsigned IdxW     = $clog2(MaxTerms);
  localparam int unsigned CntW     = $clog2(MaxTerms + 1);
  localparam int unsigned CoefW    = 30;
  localparam int unsigned TermW    = 10;
  localparam logic [CoefW-1:0] Prime  = 30'd1000000007;
  localparam logic [CoefW-1:0] PrimeM2 = 30'd1000000005;
  localparam int unsigned ExpW     = 30;

  // Shared multiplier operand width and Barrett constant floor(2^60 / Prime)
  localparam int unsigned MulW     = 32;
  localparam logic [MulW-1:0] BarrettMu = 32'd1152921496;

  typedef struct packed {
    logic [CoefW-1:0] num_coef;
    logic [CoefW-1:0] den_coef;
    logic             first;
  } req_t;

  typedef struct packed {
    logic [CoefW-1:0] quot_coef;
    logic [TermW-1:0] term_index;
    logic             lead_zero_error;
    logic             overflow;
  } rsp_t;

endpackage

### rtl/psd_if.sv
interface psd_req_if;
  import psd_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface psd_rsp_if;
  import psd_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/psd_modmul.sv
// Sequential modular multiplier around one 32x32 multiplier: the 60-bit
// product, then a Barrett quotient estimate, then the remainder, then up to
// two corrective subtractions of the prime. Done pulses after the correction
// phase, with the result held on p_o until the next start.
module psd_modmul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [psd_pkg::CoefW-1:0]    x_i,
  input  logic [psd_pkg::CoefW-1:0]    y_i,
  output logic                         done_o,
  output logic [psd_pkg::CoefW-1:0]    p_o
);
  import psd_pkg::*;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhEst  = 2'd1;
  localparam logic [1:0] PhRem  = 2'd2;
  localparam logic [1:0] PhFix  = 2'd3;

  logic [1:0]         ph_q, ph_d;
  logic               done_q, done_d;
  logic [2*CoefW-1:0] prod_q, prod_d;
  logic [CoefW:0]     est_q, est_d;
  logic [MulW-1:0]    rem_q, rem_d;
  logic [CoefW-1:0]   p_q, p_d;
  logic [MulW-1:0]    op_a, op_b;
  logic [2*MulW-1:0]  mul_w;
  logic [MulW-1:0]    fix1_w, fix2_w;

  // Select the operands of the shared multiplier by phase
  always_comb begin
    op_a = MulW'(x_i);
    op_b = MulW'(y_i);
    case (ph_q)
      PhEst: begin
        op_a = MulW'(prod_q[2*CoefW-1:CoefW-1]);
        op_b = BarrettMu;
      end
      PhRem: begin
        op_a = MulW'(est_q);
        op_b = MulW'(Prime);
      end
      default: ;
    endcase
  end

  assign mul_w = {{MulW{1'b0}}, op_a} * {{MulW{1'b0}}, op_b};

  // Remainder is below three primes; subtract the prime at most twice
  assign fix1_w = (rem_q >= MulW'(Prime)) ? rem_q - MulW'(Prime) : rem_q;
  assign fix2_w = (fix1_w >= MulW'(Prime)) ? fix1_w - MulW'(Prime) : fix1_w;

  // Advance product, estimate, remainder and correction
  always_comb begin
    ph_d   = ph_q;
    prod_d = prod_q;
    est_d  = est_q;
    rem_d  = rem_q;
    p_d    = p_q;
    done_d = 1'b0;
    case (ph_q)
      PhIdle: if (start_i) begin
        prod_d = mul_w[2*CoefW-1:0];
        ph_d   = PhEst;
      end
      PhEst: begin
        est_d = mul_w[2*CoefW+1:CoefW+1];
        ph_d  = PhRem;
      end
      PhRem: begin
        rem_d = prod_q[MulW-1:0] - mul_w[MulW-1:0];
        ph_d  = PhFix;
      end
      PhFix: begin
        p_d    = fix2_w[CoefW-1:0];
        done_d = 1'b1;
        ph_d   = PhIdle;
      end
      default: ph_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PhIdle;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    est_q  <= est_d;
    rem_q  <= rem_d;
    p_q    <= p_d;
  end

  assign done_o = done_q;
  assign p_o    = p_q;
endmodule

### rtl/power_series_div_mod_prime.sv
// Online power series division modulo 1000000007.
// Request channel req (num_coef, den_coef, first); response channel rsp
// (quot_coef, term_index, lead_zero_error, overflow), valid/ready each.
// One response per request. A request is taken only while the block is
// idle and its response register is empty or being drained.
// Term i runs i multiply-accumulate steps through one shared modular
// multiplier (a 32x32 product and a Barrett reduction; each accumulate step
// first reads both stores) plus one final multiply by the leading inverse;
// term zero with a nonzero lead also runs a 30-bit square-and-multiply
// exponentiation (45 multiplies). A normal response is registered and raised
// in StOut after the final multiply; an overflow response is valid in the
// cycle after the request is taken.
// The denominator and quotient stores each have one write and one read port,
// read one entry a cycle; unwritten entries are never used.
// Reset clears the control state and term counter; the next request is
// taken as term zero. A stalled response holds in its register and the
// block accepts no further request until it is taken.
module power_series_div_mod_prime (
  input logic clk_i,
  input logic rst_ni,
  psd_req_if.sink   req,
  psd_rsp_if.source rsp
);
  import psd_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StPow   = 4'd1;
  localparam logic [3:0] StPowW  = 4'd2;
  localparam logic [3:0] StRdQ   = 4'd3;
  localparam logic [3:0] StRdB   = 4'd4;
  localparam logic [3:0] StMacW  = 4'd5;
  localparam logic [3:0] StFin   = 4'd6;
  localparam logic [3:0] StFinW  = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;
  localparam logic [3:0] StPowSq = 4'd9;
  localparam logic [3:0] StSqW   = 4'd10;
  localparam logic [3:0] StRdQ2  = 4'd11;

  logic [CoefW-1:0] den_mem [MaxTerms];
  logic [CoefW-1:0] quot_mem [MaxTerms];

  logic [3:0]       st_q;
  logic [CntW-1:0]  cnt_q;
  logic [IdxW-1:0]  i_q, j_q;
  logic [CoefW-1:0] a_q, acc_q, inv_q, base_q, qrd_q, brd_q;
  logic [4:0]       bit_q;
  logic             bad_q;
  logic             ovf_q;
  logic             rsp_vld_q;
  rsp_t             rsp_q;

  logic             mul_start;
  logic [CoefW-1:0] mul_x, mul_y, mul_p;
  logic             mul_done;
  logic [CoefW-1:0] a_red, b_red;
  logic             take;
  logic [CntW-1:0]  i_eff;
  logic [CoefW-1:0] sub_w;

  psd_modmul u_mul (
    .clk_i, .rst_ni,
    .start_i(mul_start), .x_i(mul_x), .y_i(mul_y),
    .done_o(mul_done), .p_o(mul_p)
  );

  assign req.ready = (st_q == StIdle) && (!rsp_vld_q || rsp.ready);
  assign take      = req.valid && req.ready;
  assign a_red = (req.payload.num_coef >= Prime) ? req.payload.num_coef - Prime
                                                 : req.payload.num_coef;
  assign b_red = (req.payload.den_coef >= Prime) ? req.payload.den_coef - Prime
                                                 : req.payload.den_coef;
  assign i_eff = req.payload.first ? '0 : cnt_q;
  assign rsp.valid   = rsp_vld_q;
  assign rsp.payload = rsp_q;

  // acc - product mod P
  assign sub_w = (acc_q >= mul_p) ? acc_q - mul_p : acc_q + (Prime - mul_p);

  // Drive the shared multiplier operands
  always_comb begin
    mul_start = 1'b0;
    mul_x = qrd_q;
    mul_y = brd_q;
    case (st_q)
      StPow:   begin mul_start = 1'b1; mul_x = acc_q;  mul_y = base_q; end
      StPowSq: begin mul_start = 1'b1; mul_x = base_q; mul_y = base_q; end
      StRdQ2:  begin mul_start = 1'b1; end
      StFin:   begin mul_start = 1'b1; mul_x = acc_q; mul_y = inv_q; end
      default: ;
    endcase
  end

  // Store the denominator and quotient terms and read operands
  always_ff @(posedge clk_i) begin
    if (take && !ovf_q && !(i_eff >= CntW'(MaxTerms)))
      den_mem[i_eff[IdxW-1:0]] <= b_red;
    if (st_q == StFinW && mul_done)
      quot_mem[i_q] <= bad_q ? '0 : mul_p;
    qrd_q <= quot_mem[j_q];
    brd_q <= den_mem[i_q - j_q];
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; inv_q <= '0; bad_q <= 1'b0;
      rsp_vld_q <= 1'b0; ovf_q <= 1'b0;
      i_q <= '0; j_q <= '0; a_q <= '0; acc_q <= '0; base_q <= '0; bit_q <= '0;
      rsp_q <= '0;
    end else begin
      if (rsp_vld_q && rsp.ready) rsp_vld_q <= 1'b0;
      case (st_q)
        StIdle: if (take) begin
          ovf_q <= 1'b0;
          if (i_eff >= CntW'(MaxTerms)) begin
            cnt_q <= i_eff;
            rsp_q <= '{quot_coef: '0, term_index: '0,
                       lead_zero_error: bad_q, overflow: 1'b1};
            rsp_vld_q <= 1'b1;
          end else begin
            i_q <= i_eff[IdxW-1:0];
            j_q <= '0;
            a_q <= a_red;
            acc_q <= a_red;
            if (i_eff == '0) begin
              bad_q <= (b_red == '0);
              if (b_red == '0) begin
                inv_q <= '0;
                st_q <= StFin;
              end else begin
                acc_q <= 30'd1;
                base_q <= b_red;
                bit_q <= '0;
                st_q <= PrimeM2[0] ? StPow : StPowSq;
              end
            end else begin
              st_q <= StRdQ;
            end
          end
        end
        // Square-and-multiply for the leading inverse
        StPow:  st_q <= StPowW;
        StPowW: if (mul_done) begin acc_q <= mul_p; st_q <= StPowSq; end
        StPowSq: st_q <= StSqW;
        StSqW: if (mul_done) begin
          base_q <= mul_p;
          if (bit_q == 5'(ExpW - 1)) begin
            inv_q <= acc_q;
            acc_q <= a_q;
            st_q <= StFin;
          end else begin
            bit_q <= bit_q + 1'b1;
            st_q <= PrimeM2[bit_q + 1'b1] ? StPow : StPowSq;
          end
        end
        // Accumulate q_j * b_(i-j) over j < i
        StRdQ:  st_q <= StRdB;
        StRdB:  st_q <= StRdQ2;
        StRdQ2: st_q <= StMacW;
        StMacW: if (mul_done) begin
          acc_q <= sub_w;
          if (j_q + 1'b1 == i_q) st_q <= StFin;
          else begin j_q <= j_q + 1'b1; st_q <= StRdQ; end
        end
        StFin:  st_q <= StFinW;
        StFinW: if (mul_done) begin
          rsp_q <= '{quot_coef: bad_q ? '0 : mul_p,
                     term_index: TermW'(i_q),
                     lead_zero_error: bad_q, overflow: 1'b0};
          cnt_q <= CntW'(i_q) + 1'b1;
          st_q <= StOut;
        end
        StOut: begin rsp_vld_q <= 1'b1; st_q <= StIdle; end
        default: st_q <= StIdle;
      endcase
    end
  end

  // Response register holds while the receiver stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && !rsp.ready |=> rsp_vld_q && $stable(rsp_q))
    else $error("response dropped under stall");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != StIdle |-> !req.ready)
    else $error("request taken while busy");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.payload.lead_zero_error && !rsp.payload.overflow
      |-> rsp.payload.quot_coef == '0)
    else $error("nonzero quotient with bad lead");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxTerms))
    else $error("term counter out of range");
endmodule
